[design/trajectory_frame_indexer_top_assert.svh]
// Assertion macros for the trajectory frame indexer.
`ifndef TRAJECTORY_FRAME_INDEXER_TOP_ASSERT_SVH
`define TRAJECTORY_FRAME_INDEXER_TOP_ASSERT_SVH

`ifndef SYNTH
`define TFI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TFI_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TFI_ASSERT(lbl, clk, rst_n, prop, msg)
`define TFI_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

[design/tfi_pkg.sv]
// Shared types, constants and tables of the trajectory frame indexer.
`default_nettype none

package tfi_pkg;

  localparam int OFFSET_W = 48;
  localparam int FCOUNT_W = 32;
  localparam int ATOM_W   = 31;
  localparam int STEP_W   = 32;
  localparam int WORD_W   = 32;
  localparam int PAY_W    = 33;
  localparam int TDATA_W  = 152;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  localparam int NSIZES  = 10;
  localparam int SIZE_IW = $clog2(NSIZES);

  localparam logic [WORD_W-1:0] MAGIC_WORD  = 32'd1993;
  localparam logic [WORD_W-1:0] VSTORE_LEN  = 32'd13;
  localparam logic [WORD_W-1:0] VTEXT_LEN   = 32'd12;
  localparam int                VEC_DIM     = 3;
  localparam int                MAT_ELEMS   = 9;
  localparam logic [ATOM_W-1:0] MAT_SINGLE  = ATOM_W'(MAT_ELEMS * 4);
  localparam logic [ATOM_W-1:0] MAT_DOUBLE  = ATOM_W'(MAT_ELEMS * 8);
  localparam logic [PAY_W-1:0]  PAY_STEP    = PAY_W'(4);

  typedef enum logic [1:0] {
    KIND_FRAME   = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_MAGIC         = 4'd1,
    ST_VERSION_LEN   = 4'd2,
    ST_VERSION_TEXT  = 4'd3,
    ST_NEG_SIZE      = 4'd4,
    ST_ATOMS         = 4'd5,
    ST_LEGACY        = 4'd6,
    ST_NO_POS        = 4'd7,
    ST_PRECISION     = 4'd8,
    ST_SIZES         = 4'd9,
    ST_NONFINITE     = 4'd10,
    ST_TRUNC_HEADER  = 4'd11,
    ST_TRUNC_PAYLOAD = 4'd12,
    ST_ATOM_CHANGE   = 4'd13,
    ST_NO_FRAMES     = 4'd14,
    ST_EXPECTED      = 4'd15
  } status_e;

  typedef struct packed {
    kind_e                     kind;
    status_e                   status;
    logic [OFFSET_W-1:0]       frame_offset;
    logic [ATOM_W-1:0]         atom_total;
    logic signed [STEP_W-1:0]  step_number;
    logic                      double_precision;
    logic                      box_present;
    logic                      velocity_present;
    logic                      force_present;
    logic [FCOUNT_W-1:0]       frame_total;
    logic                      precision_mixed;
    logic                      run_end;
  } res_t;

  // version text as three big-endian words
  function automatic logic [WORD_W-1:0] text_word(input logic [1:0] idx);
    logic [WORD_W-1:0] w;
    case (idx)
      2'd0:    w = 32'h474D585F;
      2'd1:    w = 32'h74726E5F;
      default: w = 32'h66696C65;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[design/tfi_result_fifo.sv]
// Result queue: takes up to two results per cycle, hands out one.
`default_nettype none

`include "trajectory_frame_indexer_top_assert.svh"

module tfi_result_fifo
  import tfi_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire  [1:0] push_n_i,
  input  res_t       wr0_i,
  input  res_t       wr1_i,
  output logic       room_o,
  output logic       valid_o,
  input  wire        pop_i,
  output res_t       rd_o
);

  res_t             mem_q [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_q, wr_d;
  logic [RQ_AW-1:0] rd_q, rd_d;
  logic [RQ_CW-1:0] cnt_q, cnt_d;
  logic             pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = pop_i && valid_o;
  assign room_o  = (cnt_q <= RQ_CW'(RQ_DEPTH - 2));
  assign rd_o    = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q + RQ_AW'(push_n_i);
    rd_d  = pop ? rd_q + RQ_AW'(1) : rd_q;
    cnt_d = cnt_q + RQ_CW'(push_n_i) - RQ_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= wr0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_q + RQ_AW'(1)] <= wr1_i;
    end
  end

  `TFI_ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > RQ_CW'(RQ_DEPTH), "queue count over depth")
  `TFI_ASSERT(a_pair_room, clk_i, rst_ni, (push_n_i == 2'd2) |-> (cnt_q <= RQ_CW'(RQ_DEPTH - 2)), "pair pushed without room")
  `TFI_ASSERT(a_pop_cnt, clk_i, rst_ni, (pop && push_n_i == 2'd0) |=> (cnt_q == $past(cnt_q) - RQ_CW'(1)), "pop did not drop count")

endmodule

`default_nettype wire

[design/tfi_core.sv]
// Frame header parser, payload skipper and file bookkeeping.
`default_nettype none

`include "trajectory_frame_indexer_top_assert.svh"

module tfi_core
  import tfi_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                item_valid_i,
  input  wire  [WORD_W-1:0]  item_word_i,
  input  wire                item_last_i,
  input  wire                room_i,
  input  wire  [ATOM_W-1:0]  expected_atoms_i,
  output logic               take_o,
  output logic [1:0]         push_n_o,
  output res_t               res0_o,
  output res_t               res1_o
);

  typedef enum logic [3:0] {
    PH_MAGIC, PH_VSTORE, PH_VLEN, PH_TEXT, PH_SIZE, PH_ATOMS, PH_STEP, PH_NRE,
    PH_TIME, PH_LAMBDA, PH_PAYLOAD
  } phase_e;

  typedef enum logic [1:0] {
    PREC_NONE, PREC_SINGLE, PREC_DOUBLE
  } prec_e;

  // block size slots
  localparam logic [SIZE_IW-1:0] BS_IR   = SIZE_IW'(0);
  localparam logic [SIZE_IW-1:0] BS_E    = SIZE_IW'(1);
  localparam logic [SIZE_IW-1:0] BS_BOX  = SIZE_IW'(2);
  localparam logic [SIZE_IW-1:0] BS_VIR  = SIZE_IW'(3);
  localparam logic [SIZE_IW-1:0] BS_PRES = SIZE_IW'(4);
  localparam logic [SIZE_IW-1:0] BS_TOP  = SIZE_IW'(5);
  localparam logic [SIZE_IW-1:0] BS_SYM  = SIZE_IW'(6);
  localparam logic [SIZE_IW-1:0] BS_X    = SIZE_IW'(7);
  localparam logic [SIZE_IW-1:0] BS_V    = SIZE_IW'(8);
  localparam logic [SIZE_IW-1:0] BS_F    = SIZE_IW'(9);
  localparam logic [SIZE_IW-1:0] BS_LAST = SIZE_IW'(NSIZES - 1);

  phase_e               phase_q, phase_d;
  logic [SIZE_IW-1:0]   sidx_q, sidx_d;
  logic [1:0]           wcnt_q, wcnt_d;
  logic [ATOM_W-1:0]    bs_q [NSIZES];
  logic                 bs_we;
  logic [WORD_W-1:0]    atoms_q, atoms_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [ATOM_W-1:0]    first_atoms_q, first_atoms_d;
  prec_e                first_prec_q, first_prec_d;
  logic                 box_f_q, box_f_d;
  logic                 vel_f_q, vel_f_d;
  logic                 force_f_q, force_f_d;
  logic                 mixed_q, mixed_d;
  logic [FCOUNT_W-1:0]  frames_q, frames_d;
  logic [OFFSET_W-1:0]  pos_q, pos_d;
  logic [OFFSET_W-1:0]  fstart_q, fstart_d;
  logic [PAY_W-1:0]     pay_q, pay_d;
  logic                 hold_q, hold_d;
  logic                 vstore_bad_q, vstore_bad_d;
  logic                 text_bad_q, text_bad_d;
  logic                 nonfinite_q, nonfinite_d;
  logic                 dbl_q, dbl_d;

  logic                 take;
  logic [ATOM_W+4:0]    a12, a24, pos_ext;
  logic                 hdr_dbl;
  logic [ATOM_W-1:0]    mat;
  status_e              hdr_st;

  assign take   = item_valid_i && room_i;
  assign take_o = take;

  // header consistency, evaluated on the nre word
  assign a12     = ({5'b0, atoms_q[ATOM_W-1:0]} << 3) + ({5'b0, atoms_q[ATOM_W-1:0]} << 2);
  assign a24     = {a12[ATOM_W+3:0], 1'b0};
  assign pos_ext = {5'b0, bs_q[BS_X]};
  assign hdr_dbl = (pos_ext != a12);
  assign mat     = hdr_dbl ? MAT_DOUBLE : MAT_SINGLE;

  always_comb begin
    if (atoms_q == '0 || atoms_q[WORD_W-1]) begin
      hdr_st = ST_ATOMS;
    end else if (bs_q[BS_IR] != '0 || bs_q[BS_E] != '0 || bs_q[BS_TOP] != '0 ||
                 bs_q[BS_SYM] != '0) begin
      hdr_st = ST_LEGACY;
    end else if (bs_q[BS_X] == '0) begin
      hdr_st = ST_NO_POS;
    end else if (pos_ext != a12 && pos_ext != a24) begin
      hdr_st = ST_PRECISION;
    end else if ((bs_q[BS_BOX] != '0 && bs_q[BS_BOX] != mat) ||
                 (bs_q[BS_VIR] != '0 && bs_q[BS_VIR] != mat) ||
                 (bs_q[BS_PRES] != '0 && bs_q[BS_PRES] != mat) ||
                 (bs_q[BS_V] != '0 && bs_q[BS_V] != bs_q[BS_X]) ||
                 (bs_q[BS_F] != '0 && bs_q[BS_F] != bs_q[BS_X])) begin
      hdr_st = ST_SIZES;
    end else begin
      hdr_st = ST_OK;
    end
  end

  always_comb begin
    logic             err;
    status_e          err_st;
    logic             frame_done;
    logic             nf;
    logic             done;
    logic             bad;
    logic [1:0]       c;
    prec_e            prec;
    prec_e            fp;
    logic [PAY_W-1:0] pay_next;
    logic [PAY_W-1:0] pay_base;

    phase_d       = phase_q;
    sidx_d        = sidx_q;
    wcnt_d        = wcnt_q;
    atoms_d       = atoms_q;
    step_d        = step_q;
    first_atoms_d = first_atoms_q;
    first_prec_d  = first_prec_q;
    box_f_d       = box_f_q;
    vel_f_d       = vel_f_q;
    force_f_d     = force_f_q;
    mixed_d       = mixed_q;
    frames_d      = frames_q;
    pos_d         = pos_q;
    fstart_d      = fstart_q;
    pay_d         = pay_q;
    hold_d        = hold_q;
    vstore_bad_d  = vstore_bad_q;
    text_bad_d    = text_bad_q;
    nonfinite_d   = nonfinite_q;
    dbl_d         = dbl_q;
    bs_we         = 1'b0;
    err           = 1'b0;
    err_st        = ST_OK;
    frame_done    = 1'b0;
    nf            = 1'b0;
    done          = 1'b1;
    bad           = 1'b0;
    c             = 2'd0;
    prec          = PREC_SINGLE;
    fp            = PREC_SINGLE;
    pay_next      = '0;
    pay_base      = '0;
    push_n_o      = 2'd0;
    res0_o        = '0;
    res1_o        = '0;

    if (take && !hold_q) begin
      pos_d = pos_q + OFFSET_W'(4);
      case (phase_q)
        PH_MAGIC: begin
          fstart_d = pos_q;
          if (item_word_i != MAGIC_WORD) begin
            err    = 1'b1;
            err_st = ST_MAGIC;
          end else begin
            phase_d = PH_VSTORE;
          end
        end
        PH_VSTORE: begin
          vstore_bad_d = (item_word_i != VSTORE_LEN);
          phase_d      = PH_VLEN;
        end
        PH_VLEN: begin
          if (vstore_bad_q || item_word_i != VTEXT_LEN) begin
            err    = 1'b1;
            err_st = ST_VERSION_LEN;
          end else begin
            phase_d    = PH_TEXT;
            wcnt_d     = 2'd0;
            text_bad_d = 1'b0;
          end
        end
        PH_TEXT: begin
          c          = (wcnt_q == 2'd3) ? 2'd2 : wcnt_q;
          bad        = text_bad_q || (item_word_i != text_word(c));
          text_bad_d = bad;
          if (c == 2'd2) begin
            if (bad) begin
              err    = 1'b1;
              err_st = ST_VERSION_TEXT;
            end else begin
              phase_d = PH_SIZE;
              wcnt_d  = 2'd0;
              sidx_d  = '0;
            end
          end else begin
            wcnt_d = c + 2'd1;
          end
        end
        PH_SIZE: begin
          if (item_word_i[WORD_W-1]) begin
            err    = 1'b1;
            err_st = ST_NEG_SIZE;
          end else begin
            bs_we    = 1'b1;
            // payload length builds up as the sizes arrive
            pay_base = (sidx_q == '0) ? '0 : pay_q;
            if (sidx_q inside {BS_BOX, BS_VIR, BS_PRES, BS_X, BS_V, BS_F}) begin
              pay_d = pay_base + {2'b0, item_word_i[ATOM_W-1:0]};
            end else begin
              pay_d = pay_base;
            end
            if (sidx_q == BS_LAST) begin
              phase_d = PH_ATOMS;
              sidx_d  = '0;
            end else begin
              sidx_d = sidx_q + SIZE_IW'(1);
            end
          end
        end
        PH_ATOMS: begin
          atoms_d = item_word_i;
          phase_d = PH_STEP;
        end
        PH_STEP: begin
          step_d  = item_word_i;
          phase_d = PH_NRE;
        end
        PH_NRE: begin
          if (hdr_st != ST_OK) begin
            err    = 1'b1;
            err_st = hdr_st;
          end else begin
            dbl_d       = hdr_dbl;
            phase_d     = PH_TIME;
            wcnt_d      = 2'd0;
            nonfinite_d = 1'b0;
          end
        end
        PH_TIME, PH_LAMBDA: begin
          nf = nonfinite_q;
          if (wcnt_q == 2'd0) begin
            if (dbl_q) begin
              if (&item_word_i[30:20]) nf = 1'b1;
              done = 1'b0;
            end else if (&item_word_i[30:23]) begin
              nf = 1'b1;
            end
          end
          nonfinite_d = nf;
          if (!done) begin
            wcnt_d = 2'd1;
          end else begin
            wcnt_d = 2'd0;
            if (phase_q == PH_TIME) begin
              phase_d = PH_LAMBDA;
            end else if (nf) begin
              err    = 1'b1;
              err_st = ST_NONFINITE;
            end else if (first_atoms_q != '0 && first_atoms_q != atoms_q[ATOM_W-1:0]) begin
              err    = 1'b1;
              err_st = ST_ATOM_CHANGE;
            end else begin
              prec = dbl_q ? PREC_DOUBLE : PREC_SINGLE;
              fp   = (first_prec_q == PREC_NONE) ? prec : first_prec_q;
              if (first_atoms_q == '0) first_atoms_d = atoms_q[ATOM_W-1:0];
              first_prec_d = fp;
              if (fp != prec) mixed_d = 1'b1;
              if (bs_q[BS_BOX] != '0) box_f_d = 1'b1;
              if (bs_q[BS_V] != '0) vel_f_d = 1'b1;
              if (bs_q[BS_F] != '0) force_f_d = 1'b1;
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          pay_next = (pay_q >= PAY_STEP) ? pay_q - PAY_STEP : '0;
          pay_d    = pay_next;
          if (pay_next == '0) begin
            frame_done = 1'b1;
            frames_d   = (&frames_q) ? frames_q : frames_q + FCOUNT_W'(1);
            phase_d    = PH_MAGIC;
          end
        end
        default: begin
          phase_d = PH_MAGIC;
        end
      endcase

      if (err) begin
        res0_o.kind         = KIND_ERROR;
        res0_o.status       = err_st;
        res0_o.frame_offset = fstart_d;
        res0_o.frame_total  = frames_q;
        res0_o.run_end      = 1'b1;
        push_n_o            = 2'd1;
        if (!item_last_i) hold_d = 1'b1;
      end else if (frame_done) begin
        res0_o.kind             = KIND_FRAME;
        res0_o.status           = ST_OK;
        res0_o.frame_offset     = fstart_q;
        res0_o.atom_total       = atoms_q[ATOM_W-1:0];
        res0_o.step_number      = step_q;
        res0_o.double_precision = dbl_q;
        res0_o.box_present      = (bs_q[BS_BOX] != '0);
        res0_o.velocity_present = (bs_q[BS_V] != '0);
        res0_o.force_present    = (bs_q[BS_F] != '0);
        res0_o.frame_total      = frames_d;
        res0_o.run_end          = !item_last_i;
        push_n_o                = 2'd1;
        if (item_last_i) begin
          push_n_o           = 2'd2;
          res1_o.atom_total  = first_atoms_q;
          res1_o.frame_total = frames_d;
          res1_o.run_end     = 1'b1;
          if (expected_atoms_i != '0 && expected_atoms_i != first_atoms_q) begin
            res1_o.kind   = KIND_ERROR;
            res1_o.status = ST_EXPECTED;
          end else begin
            res1_o.kind             = KIND_SUMMARY;
            res1_o.status           = ST_OK;
            res1_o.double_precision = (first_prec_q == PREC_DOUBLE);
            res1_o.box_present      = box_f_q;
            res1_o.velocity_present = vel_f_q;
            res1_o.force_present    = force_f_q;
            res1_o.precision_mixed  = mixed_q;
          end
        end
      end else if (item_last_i) begin
        res0_o.kind         = KIND_ERROR;
        res0_o.status       = (phase_d == PH_PAYLOAD) ? ST_TRUNC_PAYLOAD : ST_TRUNC_HEADER;
        res0_o.frame_offset = fstart_d;
        res0_o.frame_total  = frames_q;
        res0_o.run_end      = 1'b1;
        push_n_o            = 2'd1;
      end
    end

    // end of file: start over for the next one
    if (take && item_last_i) begin
      phase_d       = PH_MAGIC;
      sidx_d        = '0;
      wcnt_d        = 2'd0;
      atoms_d       = '0;
      step_d        = '0;
      first_atoms_d = '0;
      first_prec_d  = PREC_NONE;
      box_f_d       = 1'b0;
      vel_f_d       = 1'b0;
      force_f_d     = 1'b0;
      mixed_d       = 1'b0;
      frames_d      = '0;
      pos_d         = '0;
      fstart_d      = '0;
      pay_d         = '0;
      hold_d        = 1'b0;
      vstore_bad_d  = 1'b0;
      text_bad_d    = 1'b0;
      nonfinite_d   = 1'b0;
      dbl_d         = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_MAGIC;
      sidx_q        <= '0;
      wcnt_q        <= 2'd0;
      atoms_q       <= '0;
      step_q        <= '0;
      first_atoms_q <= '0;
      first_prec_q  <= PREC_NONE;
      box_f_q       <= 1'b0;
      vel_f_q       <= 1'b0;
      force_f_q     <= 1'b0;
      mixed_q       <= 1'b0;
      frames_q      <= '0;
      pos_q         <= '0;
      fstart_q      <= '0;
      pay_q         <= '0;
      hold_q        <= 1'b0;
      vstore_bad_q  <= 1'b0;
      text_bad_q    <= 1'b0;
      nonfinite_q   <= 1'b0;
      dbl_q         <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      sidx_q        <= sidx_d;
      wcnt_q        <= wcnt_d;
      atoms_q       <= atoms_d;
      step_q        <= step_d;
      first_atoms_q <= first_atoms_d;
      first_prec_q  <= first_prec_d;
      box_f_q       <= box_f_d;
      vel_f_q       <= vel_f_d;
      force_f_q     <= force_f_d;
      mixed_q       <= mixed_d;
      frames_q      <= frames_d;
      pos_q         <= pos_d;
      fstart_q      <= fstart_d;
      pay_q         <= pay_d;
      hold_q        <= hold_d;
      vstore_bad_q  <= vstore_bad_d;
      text_bad_q    <= text_bad_d;
      nonfinite_q   <= nonfinite_d;
      dbl_q         <= dbl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bs_we) begin
      bs_q[sidx_q] <= item_word_i[ATOM_W-1:0];
    end
  end

  `TFI_ASSERT(a_hold_silent, clk_i, rst_ni, (take && hold_q) |-> (push_n_o == 2'd0), "result while dropping words")
  `TFI_ASSERT(a_pair_order, clk_i, rst_ni, (push_n_o == 2'd2) |-> (res0_o.kind == KIND_FRAME && !res0_o.run_end && res1_o.run_end), "bad result pair")
  `TFI_ASSERT(a_restart, clk_i, rst_ni, (take && item_last_i) |=> (phase_q == PH_MAGIC && !hold_q && pos_q == '0), "no restart after last word")

endmodule

`default_nettype wire

[design/trajectory_frame_indexer_top.sv]
// Top level of the trajectory frame indexer: input register, parser, result queue.
//
//  channel   dir  handshake                   payload
//  s_axis    in   tvalid/tready               tdata: word; tlast: last word of file
//  m_axis    out  tvalid/tready               tuser: kind; tdata: record; tlast: run end
//  cfg       in   cfg_we_i                    cfg_wdata_i: expected atom count
//
//  One word per cycle: each word is checked or counted in a single pass between
//  the input register and the result queue. A word gives zero, one or two results;
//  the queue drains one per cycle while m_axis_tready is high. Input stalls when
//  the queue has fewer than two free slots. Reset clears all file state and the
//  expected atom count; no clearing pass.
`default_nettype none

module trajectory_frame_indexer_top
  import tfi_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [ATOM_W-1:0]   cfg_wdata_i,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire  [WORD_W-1:0]   s_axis_tdata,   // [31:0] word
  input  wire                 s_axis_tlast,
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  output logic [TDATA_W-1:0]  m_axis_tdata,   // status, frame_offset, atom_total,
                                              // step_number, double_precision,
                                              // box_present, velocity_present,
                                              // force_present, frame_total,
                                              // precision_mixed
  output logic [1:0]          m_axis_tuser,   // kind
  output logic                m_axis_tlast
);

  logic [ATOM_W-1:0] expected_q;
  logic              in_vld_q, in_vld_d;
  logic [WORD_W-1:0] in_word_q;
  logic              in_last_q;
  logic              take;
  logic              room;
  logic [1:0]        push_n;
  res_t              res0, res1, head;

  assign s_axis_tready = !in_vld_q || take;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_vld_d = 1'b1;
    end else if (take) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      expected_q <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      if (cfg_we_i) expected_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_word_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  tfi_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (in_vld_q),
    .item_word_i      (in_word_q),
    .item_last_i      (in_last_q),
    .room_i           (room),
    .expected_atoms_i (expected_q),
    .take_o           (take),
    .push_n_o         (push_n),
    .res0_o           (res0),
    .res1_o           (res1)
  );

  tfi_result_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .wr0_i    (res0),
    .wr1_i    (res1),
    .room_o   (room),
    .valid_o  (m_axis_tvalid),
    .pop_i    (m_axis_tready),
    .rd_o     (head)
  );

  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.run_end;
  assign m_axis_tdata = {head.precision_mixed, head.frame_total, head.force_present,
                         head.velocity_present, head.box_present, head.double_precision,
                         head.step_number, head.atom_total, head.frame_offset,
                         head.status};

endmodule

`default_nettype wire

[sim/tb.sv]
// Testbench for the trajectory frame indexer: file word streams checked against a word-level predictor.
`default_nettype none

module tb;
  import tfi_pkg::*;

  localparam int PH_MAGIC   = 0;
  localparam int PH_VSTORE  = 1;
  localparam int PH_VLEN    = 2;
  localparam int PH_TEXT    = 3;
  localparam int PH_SIZE0   = 4;
  localparam int PH_ATOMS   = 14;
  localparam int PH_STEP    = 15;
  localparam int PH_NRE     = 16;
  localparam int PH_TIME    = 17;
  localparam int PH_LAMBDA  = 18;
  localparam int PH_PAYLOAD = 19;

  localparam int PHASE_WORDS = 120;
  localparam int SETTLE      = 20;

  typedef enum int {
    F_NONE, F_MAGIC, F_VSTORE, F_VLEN, F_TEXT, F_NEG, F_ATOMS_ZERO, F_ATOMS_NEG,
    F_LEGACY, F_NOPOS, F_PREC, F_SIZES, F_NONFIN, F_GARBLE, F_COUNT
  } flaw_e;

  typedef struct packed {
    logic [WORD_W-1:0] w;
    logic              last;
  } file_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [ATOM_W-1:0]   cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [WORD_W-1:0]   s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;

  trajectory_frame_indexer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  int unsigned          ph;
  logic [1:0]           sub;
  logic [31:0]          blk [10];
  logic [31:0]          cur_atoms;
  logic [31:0]          cur_step;
  logic [31:0]          file_atoms;
  logic [1:0]           file_prec;
  logic [3:0]           fflags;
  logic [FCOUNT_W-1:0]  nframes;
  logic [OFFSET_W-1:0]  bpos;
  logic [OFFSET_W-1:0]  fstart;
  logic [63:0]          pay_left;
  bit                   holding;
  bit                   vs_bad;
  bit                   txt_bad;
  bit                   nonfin;
  bit                   dbl;
  logic [ATOM_W-1:0]    want_atoms;
  logic [31:0]          ver_text [3] = '{32'h474D585F, 32'h74726E5F, 32'h66696C65};

  res_t        expected_records [$];
  file_word_t  pending [$];
  file_word_t  on_bus;
  file_word_t  fw_item;
  logic [31:0] file_words [$];
  bit          file_cut;
  res_t        want;
  res_t        got;
  int          errors = 0;
  int          words_in = 0;
  bit          calm;

  assign calm = (words_in >= 300) && (words_in < 550);

  task automatic add_word(input logic [31:0] w);
    file_words.insert(file_words.size(), w);
  endtask

  task automatic queue_result(input res_t r);
    expected_records.insert(expected_records.size(), r);
  endtask

  task automatic restart_file();
    int i;
    ph = PH_MAGIC;
    sub = '0;
    for (i = 0; i < 10; i++) blk[i] = '0;
    cur_atoms = '0;
    cur_step = '0;
    file_atoms = '0;
    file_prec = '0;
    fflags = '0;
    nframes = '0;
    bpos = '0;
    fstart = '0;
    pay_left = '0;
    holding = 1'b0;
    vs_bad = 1'b0;
    txt_bad = 1'b0;
    nonfin = 1'b0;
    dbl = 1'b0;
  endtask

  task automatic push_fault(input status_e st, input bit last, input bit file_level);
    res_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.status = st;
    r.frame_offset = file_level ? '0 : fstart;
    r.atom_total = (st == ST_EXPECTED) ? file_atoms[ATOM_W-1:0] : '0;
    r.frame_total = nframes;
    r.run_end = 1'b1;
    queue_result(r);
    if (last) restart_file();
    else holding = 1'b1;
  endtask

  task automatic push_summary();
    res_t r;
    r = '0;
    if (nframes == '0) begin
      push_fault(ST_NO_FRAMES, 1'b1, 1'b1);
    end else if (want_atoms != '0 && {1'b0, want_atoms} != file_atoms) begin
      push_fault(ST_EXPECTED, 1'b1, 1'b1);
    end else begin
      r.kind = KIND_SUMMARY;
      r.status = ST_OK;
      r.atom_total = file_atoms[ATOM_W-1:0];
      r.double_precision = (file_prec == 2'd2);
      r.box_present = fflags[0];
      r.velocity_present = fflags[1];
      r.force_present = fflags[2];
      r.frame_total = nframes;
      r.precision_mixed = fflags[3];
      r.run_end = 1'b1;
      queue_result(r);
      restart_file();
    end
  endtask

  task automatic judge_header(output status_e st);
    logic [63:0] a, p, vec, mat;
    st = ST_OK;
    if (cur_atoms == '0 || cur_atoms[31]) begin
      st = ST_ATOMS;
    end else if (blk[0] != '0 || blk[1] != '0 || blk[5] != '0 || blk[6] != '0) begin
      st = ST_LEGACY;
    end else if (blk[7] == '0) begin
      st = ST_NO_POS;
    end else begin
      a = {32'd0, cur_atoms};
      p = {32'd0, blk[7]};
      if (p == a * 12) dbl = 1'b0;
      else if (p == a * 24) dbl = 1'b1;
      else st = ST_PRECISION;
      if (st == ST_OK) begin
        mat = dbl ? 64'd72 : 64'd36;
        vec = p;
        if ((blk[2] != '0 && blk[2] != mat) || (blk[3] != '0 && blk[3] != mat) ||
            (blk[4] != '0 && blk[4] != mat) || (blk[8] != '0 && blk[8] != vec) ||
            (blk[9] != '0 && blk[9] != vec)) begin
          st = ST_SIZES;
        end else begin
          pay_left = {32'd0, blk[2]} + blk[3] + blk[4] + blk[7] + blk[8] + blk[9];
        end
      end
    end
  endtask

  task automatic index_word(input logic [31:0] w, input bit last);
    logic [OFFSET_W-1:0] here;
    bit                  fin;
    bit                  done_w;
    int unsigned         c;
    status_e             st;
    res_t                r;
    here = bpos;
    fin = 1'b0;
    if (holding) begin
      if (last) restart_file();
    end else begin
      bpos = bpos + 4;
      if (ph == PH_MAGIC) begin
        fstart = here;
        if (w != MAGIC_WORD) begin
          push_fault(ST_MAGIC, last, 1'b0);
          fin = 1'b1;
        end else ph = PH_VSTORE;
      end else if (ph == PH_VSTORE) begin
        vs_bad = (w != 32'd13);
        ph = PH_VLEN;
      end else if (ph == PH_VLEN) begin
        if (vs_bad || w != 32'd12) begin
          push_fault(ST_VERSION_LEN, last, 1'b0);
          fin = 1'b1;
        end else begin
          ph = PH_TEXT;
          sub = '0;
          txt_bad = 1'b0;
        end
      end else if (ph == PH_TEXT) begin
        c = sub;
        if (c > 2) c = 2;
        if (w != ver_text[c]) txt_bad = 1'b1;
        if (c == 2) begin
          if (txt_bad) begin
            push_fault(ST_VERSION_TEXT, last, 1'b0);
            fin = 1'b1;
          end else begin
            ph = PH_SIZE0;
            sub = '0;
          end
        end else sub = c + 1;
      end else if (ph >= PH_SIZE0 && ph < PH_ATOMS) begin
        if (w[31]) begin
          push_fault(ST_NEG_SIZE, last, 1'b0);
          fin = 1'b1;
        end else begin
          blk[ph - PH_SIZE0] = w;
          ph = ph + 1;
        end
      end else if (ph == PH_ATOMS) begin
        cur_atoms = w;
        ph = PH_STEP;
      end else if (ph == PH_STEP) begin
        cur_step = w;
        ph = PH_NRE;
      end else if (ph == PH_NRE) begin
        judge_header(st);
        if (st != ST_OK) begin
          push_fault(st, last, 1'b0);
          fin = 1'b1;
        end else begin
          ph = PH_TIME;
          sub = '0;
          nonfin = 1'b0;
        end
      end else if (ph == PH_TIME || ph == PH_LAMBDA) begin
        done_w = 1'b1;
        if (sub == '0) begin
          if (dbl) begin
            if (w[30:20] == 11'h7FF) nonfin = 1'b1;
            done_w = 1'b0;
          end else if (w[30:23] == 8'hFF) nonfin = 1'b1;
        end
        if (!done_w) begin
          sub = 2'd1;
        end else begin
          sub = '0;
          if (ph == PH_TIME) begin
            ph = PH_LAMBDA;
          end else if (nonfin) begin
            push_fault(ST_NONFINITE, last, 1'b0);
            fin = 1'b1;
          end else if (file_atoms != '0 && file_atoms != cur_atoms) begin
            push_fault(ST_ATOM_CHANGE, last, 1'b0);
            fin = 1'b1;
          end else begin
            if (file_atoms == '0) file_atoms = cur_atoms;
            if (file_prec == '0) file_prec = dbl ? 2'd2 : 2'd1;
            if (file_prec != (dbl ? 2'd2 : 2'd1)) fflags[3] = 1'b1;
            if (blk[2] != '0) fflags[0] = 1'b1;
            if (blk[8] != '0) fflags[1] = 1'b1;
            if (blk[9] != '0) fflags[2] = 1'b1;
            ph = PH_PAYLOAD;
          end
        end
      end else if (ph == PH_PAYLOAD) begin
        pay_left = (pay_left >= 4) ? pay_left - 4 : '0;
        if (pay_left == '0) begin
          if (nframes != '1) nframes = nframes + 1;
          r = '0;
          r.kind = KIND_FRAME;
          r.status = ST_OK;
          r.frame_offset = fstart;
          r.atom_total = cur_atoms[ATOM_W-1:0];
          r.step_number = cur_step;
          r.double_precision = dbl;
          r.box_present = (blk[2] != '0);
          r.velocity_present = (blk[8] != '0);
          r.force_present = (blk[9] != '0);
          r.frame_total = nframes;
          r.run_end = !last;
          queue_result(r);
          ph = PH_MAGIC;
          if (last) push_summary();
          fin = 1'b1;
        end
      end else begin
        ph = PH_MAGIC;
      end
      if (!fin && last)
        push_fault((ph == PH_PAYLOAD) ? ST_TRUNC_PAYLOAD : ST_TRUNC_HEADER, 1'b1, 1'b0);
    end
  endtask

  task automatic check_field(input string nm, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", nm, e, a);
      errors++;
    end
  endtask

  // driver: one item on the bus at a time, predicted when accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tlast <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        index_word(on_bus.w, on_bus.last);
        words_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
          on_bus = pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= on_bus.w;
          s_axis_tlast <= on_bus.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = kind_e'(m_axis_tuser);
        got.status = status_e'(m_axis_tdata[3:0]);
        got.frame_offset = m_axis_tdata[51:4];
        got.atom_total = m_axis_tdata[82:52];
        got.step_number = m_axis_tdata[114:83];
        got.double_precision = m_axis_tdata[115];
        got.box_present = m_axis_tdata[116];
        got.velocity_present = m_axis_tdata[117];
        got.force_present = m_axis_tdata[118];
        got.frame_total = m_axis_tdata[150:119];
        got.precision_mixed = m_axis_tdata[151];
        got.run_end = m_axis_tlast;
        if (expected_records.size() == 0) begin
          $error("unexpected result: kind %0d status %0d", got.kind, got.status);
          errors++;
        end else begin
          want = expected_records.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("status", want.status, got.status);
          check_field("frame_offset", want.frame_offset, got.frame_offset);
          check_field("atom_total", want.atom_total, got.atom_total);
          check_field("step_number", want.step_number, got.step_number);
          check_field("double_precision", want.double_precision, got.double_precision);
          check_field("box_present", want.box_present, got.box_present);
          check_field("velocity_present", want.velocity_present, got.velocity_present);
          check_field("force_present", want.force_present, got.force_present);
          check_field("frame_total", want.frame_total, got.frame_total);
          check_field("precision_mixed", want.precision_mixed, got.precision_mixed);
          check_field("run_end", want.run_end, got.run_end);
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 23);
    end
  end

  task automatic add_frame(input logic [31:0] atoms, input bit dp, input flaw_e flaw);
    logic [31:0] sz [10];
    logic [31:0] vec, mat, aw, hw;
    logic [63:0] pay;
    int unsigned i, j, base, nw;
    base = file_words.size();
    for (i = 0; i < 10; i++) sz[i] = '0;
    vec = atoms * (dp ? 32'd24 : 32'd12);
    mat = dp ? 32'd72 : 32'd36;
    sz[2] = $urandom_range(1) ? mat : '0;
    sz[3] = $urandom_range(1) ? mat : '0;
    sz[4] = $urandom_range(1) ? mat : '0;
    sz[7] = vec;
    sz[8] = $urandom_range(1) ? vec : '0;
    sz[9] = $urandom_range(1) ? vec : '0;
    aw = atoms;
    case (flaw)
      F_NEG: begin
        j = $urandom_range(9);
        sz[j][31] = 1'b1;
      end
      F_ATOMS_ZERO: aw = '0;
      F_ATOMS_NEG: aw[31] = 1'b1;
      F_LEGACY: begin
        case ($urandom_range(3))
          0: j = 0;
          1: j = 1;
          2: j = 5;
          default: j = 6;
        endcase
        sz[j] = $urandom_range(1, 1000);
      end
      F_NOPOS: sz[7] = '0;
      F_PREC: sz[7] = vec + 4;
      F_SIZES: begin
        case ($urandom_range(4))
          0: sz[2] = mat + 4;
          1: sz[3] = mat + 4;
          2: sz[4] = mat + 4;
          3: sz[8] = vec + 4;
          default: sz[9] = vec + 4;
        endcase
      end
      default: ;
    endcase
    add_word((flaw == F_MAGIC) ? (MAGIC_WORD ^ (32'd1 << $urandom_range(31))) : MAGIC_WORD);
    add_word((flaw == F_VSTORE) ? (32'd13 ^ (32'd1 << $urandom_range(31))) : 32'd13);
    add_word((flaw == F_VLEN) ? (32'd12 ^ (32'd1 << $urandom_range(31))) : 32'd12);
    j = $urandom_range(2);
    for (i = 0; i < 3; i++)
      add_word((flaw == F_TEXT && i == j) ?
               (ver_text[i] ^ (32'd1 << $urandom_range(31))) : ver_text[i]);
    for (i = 0; i < 10; i++) add_word(sz[i]);
    add_word(aw);
    add_word($urandom);
    add_word($urandom);
    j = $urandom_range(1);
    for (i = 0; i < 2; i++) begin
      hw = $urandom;
      if (dp) begin
        if (hw[30:20] == 11'h7FF) hw[20] = 1'b0;
        if (flaw == F_NONFIN && i == j) hw[30:20] = 11'h7FF;
        add_word(hw);
        add_word($urandom);
      end else begin
        if (hw[30:23] == 8'hFF) hw[23] = 1'b0;
        if (flaw == F_NONFIN && i == j) hw[30:23] = 8'hFF;
        add_word(hw);
      end
    end
    pay = {32'd0, sz[2]} + sz[3] + sz[4] + sz[7] + sz[8] + sz[9];
    if (pay > 64'd600) begin
      nw = $urandom_range(0, 3);
      file_cut = 1'b1;
    end else begin
      nw = pay / 4;
    end
    for (i = 0; i < nw; i++) add_word($urandom);
    if (flaw == F_GARBLE) file_words[$urandom_range(base, file_words.size() - 1)] = $urandom;
  endtask

  task automatic flush_file();
    int i;
    for (i = 0; i < file_words.size(); i++) begin
      fw_item.w = file_words[i];
      fw_item.last = (i == file_words.size() - 1);
      pending.insert(pending.size(), fw_item);
    end
    file_words.delete();
    file_cut = 1'b0;
  endtask

  task automatic build_file();
    int unsigned nfr, k, n, r, flaw_frame;
    logic [31:0] atoms, atoms_k;
    bit          dp;
    flaw_e       flaw;
    file_words.delete();
    file_cut = 1'b0;
    if ($urandom_range(99) < 8) begin
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++) add_word($urandom);
    end else begin
      nfr = $urandom_range(1, 3);
      r = $urandom_range(99);
      if (r < 80) atoms = $urandom_range(1, 3);
      else if (r < 90) atoms = $urandom_range(4, 6);
      else if (r < 96) atoms = $urandom_range(7, 5000);
      else if (r < 98) atoms = 32'h7FFFFFFF;
      else atoms = $urandom & 32'h7FFFFFFF;
      dp = $urandom_range(1);
      flaw = ($urandom_range(99) < 35) ? flaw_e'($urandom_range(1, F_COUNT - 1)) : F_NONE;
      flaw_frame = $urandom_range(0, nfr - 1);
      for (k = 0; k < nfr && !file_cut; k++) begin
        atoms_k = (k > 0 && $urandom_range(99) < 10) ? atoms + 1 : atoms;
        add_frame(atoms_k, dp ^ ($urandom_range(99) < 15), (k == flaw_frame) ? flaw : F_NONE);
      end
      if (!file_cut && $urandom_range(99) < 12) begin
        n = $urandom_range(1, file_words.size());
        while (file_words.size() > n) file_words.delete(file_words.size() - 1);
      end
    end
    flush_file();
  endtask

  task automatic write_limit(input logic [ATOM_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    want_atoms = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending.size() != 0 || s_axis_tvalid || expected_records.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    logic [ATOM_W-1:0] limits [6];
    int p;
    restart_file();
    want_atoms = '0;
    limits[0] = '0;
    limits[1] = 31'd2;
    limits[2] = 31'd1;
    limits[3] = 31'h7FFFFFFF;
    limits[4] = $urandom;
    limits[5] = 31'd3;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (p = 0; p < 6; p++) begin
      write_limit(limits[p]);
      if (p == 0) begin
        // all-ones word as a bad magic, header cut short, one clean frame
        add_word(32'hFFFFFFFF);
        flush_file();
        add_word(MAGIC_WORD);
        add_word(32'd13);
        flush_file();
        add_frame(32'd1, 1'b0, F_NONE);
        flush_file();
      end
      while (pending.size() < PHASE_WORDS) build_file();
      drain();
    end
    if (errors == 0 && expected_records.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

endmodule

`default_nettype wire
